>>> hw/rtl/mct_pkg.sv
// Shared constants, types and helpers for the multiset counting table.
package mct_pkg;

  localparam int ENTRIES    = 64;
  localparam int COUNT_BITS = 16;
  localparam int TOTAL_BITS = 24;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // widths that hold a sum before saturation
  localparam int SUM_W  = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;
  localparam int TSUM_W = ((COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS) + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [15:0]        amount;
  } req_t;

  typedef struct packed {
    logic [15:0]           multiplicity;
    logic                  present;
    logic [TOTAL_BITS-1:0] total_copies;
    logic                  is_empty;
    logic signed [31:0]    front_value;
    logic                  table_full;
  } rsp_t;

  typedef struct packed {
    logic signed [31:0]    value;
    logic [COUNT_BITS-1:0] count;
    logic                  used;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_PULL,
    CELL_SET
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [IDX_W-1:0]      slot;
    logic [COUNT_BITS-1:0] count;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY
  } state_t;

  // count shown on the 16-bit result field, saturated if the count is wider
  function automatic logic [15:0] mult16(input logic [COUNT_BITS-1:0] c);
    logic [SUM_W-1:0] w;
    w = SUM_W'(c);
    return (w > SUM_W'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

>>> hw/rtl/multiset_count_table.sv
// Multiset counting table: top level with the cell chain and its sequencer.
// A transaction is taken into the request register, then its key compare is registered in
// every cell, then its shift or count update along the chain is made as its result is
// registered; no new transaction is taken while one is in its key compare.
// A stalled result holds the update step; the next request is taken as the result leaves.
// Reset (rst, synchronous) clears all used flags, counts and the total at once; no sweep.
module multiset_count_table (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  mct_pkg::req_t   req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output mct_pkg::rsp_t   rsp
);
  import mct_pkg::*;

  logic signed [31:0]          key;
  cell_cmd_t                   cmd;
  logic [ENTRIES-1:0]          hit;
  entry_t [ENTRIES-1:0]        cells;
  entry_t                      head;

  // new entry enters at the front of the chain
  assign head = '{value: key, count: cmd.count, used: 1'b1};

  mct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .key       (key),
    .cmd       (cmd),
    .hit       (hit),
    .cells     (cells)
  );

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    entry_t prev_ent, next_ent;

    if (g == 0) begin : g_first
      assign prev_ent = head;
    end else begin : g_mid
      assign prev_ent = cells[g-1];
    end

    if (g == ENTRIES - 1) begin : g_last
      assign next_ent = '0;
    end else begin : g_inner
      assign next_ent = cells[g+1];
    end

    mct_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .idx  (IDX_W'(g)),
      .key  (key),
      .cmd  (cmd),
      .prev (prev_ent),
      .next (next_ent),
      .ent  (cells[g]),
      .hit  (hit[g])
    );
  end

endmodule

>>> hw/rtl/mct_cell.sv
// One table cell: holds an entry, compares it with the key, shifts with its neighbors.
module mct_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [mct_pkg::IDX_W-1:0] idx,
  input  logic signed [31:0]   key,
  input  mct_pkg::cell_cmd_t   cmd,
  input  mct_pkg::entry_t      prev,
  input  mct_pkg::entry_t      next,
  output mct_pkg::entry_t      ent,
  output logic                 hit
);
  import mct_pkg::*;

  logic signed [31:0]    value;
  logic [COUNT_BITS-1:0] count;
  logic                  used;

  assign ent = '{value: value, count: count, used: used};

  // match is registered; key and cell contents hold still across the lookup
  always_ff @(posedge clk) begin
    hit <= used && (value == key);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: value <= prev.value;
      CELL_PULL: begin
        if (idx >= cmd.slot) value <= next.value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      used  <= 1'b0;
    end else begin
      case (cmd.op)
        CELL_INSERT: begin
          count <= prev.count;
          used  <= prev.used;
        end
        CELL_PULL: begin
          if (idx >= cmd.slot) begin
            count <= next.count;
            used  <= next.used;
          end
        end
        CELL_SET: begin
          if (idx == cmd.slot) count <= cmd.count;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/mct_ctrl.sv
// Sequencer: request register, update decision, running total and result register.
module mct_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  mct_pkg::req_t         req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output mct_pkg::rsp_t         rsp,
  output logic signed [31:0]    key,
  output mct_pkg::cell_cmd_t    cmd,
  input  logic [mct_pkg::ENTRIES-1:0] hit,
  input  mct_pkg::entry_t [mct_pkg::ENTRIES-1:0] cells
);
  import mct_pkg::*;

  state_t                state, state_next;
  req_t                  cur;
  logic [TOTAL_BITS-1:0] total, total_next;
  rsp_t                  res;
  logic                  apply_go;
  logic                  accept;

  logic [IDX_W-1:0]      slot;
  logic [COUNT_BITS-1:0] old_cnt;
  logic                  any_hit;
  logic [SUM_W-1:0]      add_sum;
  logic [SUM_W-1:0]      amt_ext;
  logic [COUNT_BITS-1:0] add_cnt;
  logic [COUNT_BITS-1:0] new_cnt;
  logic [COUNT_BITS-1:0] total_inc;
  logic [TSUM_W-1:0]     tsum;
  logic [TOTAL_BITS-1:0] total_up;
  logic [TOTAL_BITS-1:0] total_dn;
  cell_op_t              op;

  assign key       = cur.value;
  assign apply_go  = (state == ST_APPLY) && (!rsp_valid || !rsp_stall);
  assign req_stall = !((state == ST_IDLE) || apply_go);
  assign accept    = req_valid && !req_stall;

  // one-hot hit vector: encode and select by OR
  always_comb begin
    slot    = '0;
    old_cnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit[i]) begin
        slot    = slot | IDX_W'(i);
        old_cnt = old_cnt | cells[i].count;
      end
    end
    any_hit = |hit;
  end

  assign add_sum = SUM_W'(old_cnt) + SUM_W'(cur.amount);
  assign add_cnt = (add_sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : add_sum[COUNT_BITS-1:0];
  assign amt_ext = SUM_W'(cur.amount);
  assign new_cnt = (amt_ext > SUM_W'(COUNT_MAX)) ? COUNT_MAX : amt_ext[COUNT_BITS-1:0];
  // increase applied by an add: growth of an existing count, or the count of a new entry
  assign total_inc = any_hit ? add_cnt - old_cnt : new_cnt;
  assign tsum    = TSUM_W'(total) + TSUM_W'(total_inc);
  assign total_up = (tsum > TSUM_W'(TOTAL_MAX)) ? TOTAL_MAX : tsum[TOTAL_BITS-1:0];
  assign total_dn = (total != '0) ? total - 1'b1 : total;

  always_comb begin
    op               = CELL_HOLD;
    cmd.slot         = slot;
    cmd.count        = old_cnt;
    total_next       = total;
    res.multiplicity = mult16(old_cnt);
    res.present      = any_hit;
    res.table_full   = 1'b0;
    res.is_empty     = !cells[0].used;
    res.front_value  = cells[0].used ? cells[0].value : 32'sd0;
    case (cur.kind)
      KIND_ADD: begin
        if (any_hit) begin
          op               = CELL_SET;
          cmd.count        = add_cnt;
          total_next       = total_up;
          res.multiplicity = mult16(add_cnt);
        end else if (cur.amount != '0) begin
          if (cells[ENTRIES-1].used) begin
            res.table_full = 1'b1;
          end else begin
            op               = CELL_INSERT;
            cmd.count        = new_cnt;
            total_next       = total_up;
            res.multiplicity = mult16(new_cnt);
            res.present      = 1'b1;
            res.is_empty     = 1'b0;
            res.front_value  = cur.value;
          end
        end
      end
      KIND_REMOVE: begin
        if (any_hit) begin
          total_next = total_dn;
          if (old_cnt > COUNT_BITS'(1)) begin
            op               = CELL_SET;
            cmd.count        = old_cnt - 1'b1;
            res.multiplicity = mult16(old_cnt - 1'b1);
          end else begin
            op               = CELL_PULL;
            res.multiplicity = '0;
            res.present      = 1'b0;
            // dropping the front entry exposes the next one
            if (slot == '0) begin
              res.is_empty    = !cells[1].used;
              res.front_value = cells[1].used ? cells[1].value : 32'sd0;
            end
          end
        end
      end
      default: ;
    endcase
    res.total_copies = total_next;
    cmd.op = apply_go ? op : CELL_HOLD;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req_valid) state_next = ST_LOOK;
      ST_LOOK:  state_next = ST_APPLY;
      ST_APPLY: begin
        if (apply_go) state_next = req_valid ? ST_LOOK : ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      total     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (apply_go) begin
        total     <= total_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cur <= req;
    if (apply_go) rsp <= res;
  end

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) |-> $onehot0(hit))
    else $error("more than one cell matched the key");

  a_full_not_present: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.table_full) |-> !rsp.present)
    else $error("dropped add reported as present");

  a_empty_consistent: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.is_empty) |-> (rsp.front_value == 32'sd0 && !rsp.present))
    else $error("empty table reported an entry");

  a_query_keeps_total: assert property (@(posedge clk) disable iff (rst)
    (apply_go && (cur.kind == KIND_QUERY)) |=> (total == $past(total)))
    else $error("query changed the running total");

endmodule

>>> tb/multiset_count_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the multiset counting table: directed and random traffic.
module multiset_count_table_tb;
  import mct_pkg::*;

  localparam longint unsigned CNT_CAP = (64'd1 << COUNT_BITS) - 1;
  localparam longint unsigned TOT_CAP = (64'd1 << TOTAL_BITS) - 1;
  localparam logic [1:0] KIND_SPARE = 2'd3;  // unused code, behaves as a query
  localparam int VAL_POOL    = 72;           // more than ENTRIES so the table overflows
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  // Mirror of the table contents; computes the result each transaction should give.
  class multiset_tracker;
    logic signed [31:0] vals[ENTRIES];
    longint unsigned    cnts[ENTRIES];
    int                 n_used;
    longint unsigned    total;
    rsp_t               expected_q[$];
    int                 errors, n_checked, n_drops, n_emptied, peak_fill;
    int                 n_kind[4];

    function new();
      n_used = 0;
      total = 0;
      errors = 0;
      n_checked = 0;
      n_drops = 0;
      n_emptied = 0;
      peak_fill = 0;
      n_kind = '{0, 0, 0, 0};
    endfunction

    function int find(logic signed [31:0] v);
      for (int i = 0; i < n_used; i++) begin
        if (vals[i] == v) return i;
      end
      return -1;
    endfunction

    function void grow_total(longint unsigned d);
      total = (total + d > TOT_CAP) ? TOT_CAP : total + d;
    endfunction

    function string show(rsp_t x);
      return $sformatf("mult=%0d present=%0b total=%0d empty=%0b front=%0d full=%0b",
                       x.multiplicity, x.present, x.total_copies, x.is_empty,
                       x.front_value, x.table_full);
    endfunction

    function void note(req_t r);
      int              slot;
      longint unsigned old, nc;
      logic            drop;
      rsp_t            e;
      slot = find(r.value);
      drop = 1'b0;
      n_kind[r.kind]++;
      case (r.kind)
        KIND_ADD: begin
          if (slot >= 0) begin
            old = cnts[slot];
            nc = old + r.amount;
            if (nc > CNT_CAP) nc = CNT_CAP;
            cnts[slot] = nc;
            grow_total(nc - old);
          end else if (r.amount != 0) begin
            if (n_used >= ENTRIES) begin
              drop = 1'b1;
              n_drops++;
            end else begin
              for (int i = n_used; i > 0; i--) begin
                vals[i] = vals[i-1];
                cnts[i] = cnts[i-1];
              end
              vals[0] = r.value;
              cnts[0] = (r.amount > CNT_CAP) ? CNT_CAP : r.amount;
              n_used++;
              grow_total(cnts[0]);
              slot = 0;
              if (n_used > peak_fill) peak_fill = n_used;
            end
          end
        end
        KIND_REMOVE: begin
          if (slot >= 0) begin
            if (total > 0) total--;
            if (cnts[slot] > 1) begin
              cnts[slot]--;
            end else begin
              // close the gap so the entries stay packed from the front
              for (int i = slot; i + 1 < n_used; i++) begin
                vals[i] = vals[i+1];
                cnts[i] = cnts[i+1];
              end
              n_used--;
              slot = -1;
              if (n_used == 0) n_emptied++;
            end
          end
        end
        default: ;
      endcase
      e.multiplicity = (slot < 0) ? 16'd0 :
                       (cnts[slot] > 64'hFFFF) ? 16'hFFFF : 16'(cnts[slot]);
      e.present      = (slot >= 0);
      e.total_copies = TOTAL_BITS'(total);
      e.is_empty     = (n_used == 0);
      e.front_value  = (n_used > 0) ? vals[0] : 32'sd0;
      e.table_full   = drop;
      expected_q.push_back(e);
    endfunction

    function void check(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with no request pending: %s", show(got));
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (got.multiplicity !== e.multiplicity || got.present !== e.present ||
          got.total_copies !== e.total_copies || got.is_empty !== e.is_empty ||
          got.front_value !== e.front_value || got.table_full !== e.table_full) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d mismatch", n_checked);
          $display("  expected %s", show(e));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic  clk = 1'b0;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  req_t  req;
  logic  rsp_valid;
  logic  rsp_stall;
  rsp_t  rsp;
  bit    calm;
  int    cycles;
  logic signed [31:0] pool[VAL_POOL];
  multiset_tracker tracker;

  always #5 clk = ~clk;

  multiset_count_table DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // transaction monitor: both channels sampled on the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) tracker.note(req);
      if (rsp_valid && !rsp_stall) tracker.check(rsp);
    end
  end

  always @(posedge clk) begin
    rsp_stall <= !rst && !calm && ($urandom_range(0, 99) < 9);
  end

  function automatic req_t mk(logic [1:0] k, logic [31:0] v, logic [15:0] a);
    req_t r;
    r.kind = k;
    r.value = v;
    r.amount = a;
    return r;
  endfunction

  task automatic send(input req_t r);
    while (!calm && $urandom_range(0, 99) < 9) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
  endtask

  // add_pct sets the mix: high fills the table, low drains it
  task automatic send_random(input int add_pct);
    req_t r;
    int   roll, pick;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) r.kind = KIND_ADD;
    else if (roll < 93) r.kind = KIND_REMOVE;
    else if (roll < 97) r.kind = KIND_QUERY;
    else r.kind = KIND_SPARE;
    pick = $urandom_range(0, 99);
    if (r.kind == KIND_REMOVE && tracker.n_used > 0 && pick < 75)
      r.value = tracker.vals[$urandom_range(0, tracker.n_used - 1)];
    else if (pick < 85)
      r.value = pool[$urandom_range(0, VAL_POOL - 1)];
    else
      r.value = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 5) r.amount = 16'd0;
    else if (roll < 96) r.amount = 16'($urandom_range(1, 3));
    else if (roll < 98) r.amount = 16'($urandom);
    else r.amount = 16'hFFFF;
    send(r);
  endtask

  initial begin
    tracker = new();
    cycles = 0;
    calm = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    for (int i = 0; i < VAL_POOL; i++) pool[i] = $urandom;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, zero amounts, saturation, absent removes, close-up on removal
    send(mk(KIND_QUERY,  32'h0000_0000, 16'd0));
    send(mk(KIND_REMOVE, 32'h0000_0005, 16'd9));
    send(mk(KIND_ADD,    32'h8000_0000, 16'd0));
    send(mk(KIND_ADD,    32'h0000_002A, 16'd1));
    send(mk(KIND_REMOVE, 32'h0000_002A, 16'd0));
    send(mk(KIND_ADD,    32'h8000_0000, 16'd1));
    send(mk(KIND_ADD,    32'h7FFF_FFFF, 16'hFFFF));
    send(mk(KIND_ADD,    32'h7FFF_FFFF, 16'd7));
    send(mk(KIND_ADD,    32'h8000_0000, 16'd0));
    send(mk(KIND_ADD,    32'h0000_0000, 16'd2));
    send(mk(KIND_ADD,    32'hFFFF_FFFF, 16'h8000));
    send(mk(KIND_SPARE,  32'hFFFF_FFFF, 16'hFFFF));
    send(mk(KIND_QUERY,  32'h7FFF_FFFF, 16'd3));
    send(mk(KIND_REMOVE, 32'h0000_0000, 16'd0));
    send(mk(KIND_REMOVE, 32'h0000_0000, 16'd0));
    send(mk(KIND_REMOVE, 32'h8000_0000, 16'd0));
    send(mk(KIND_REMOVE, 32'hFFFF_FFFF, 16'd0));
    send(mk(KIND_QUERY,  32'h0000_0000, 16'd0));
    send(mk(KIND_REMOVE, 32'h0000_3039, 16'd0));
    send(mk(KIND_ADD,    32'h5555_5555, 16'hAAAA));
    send(mk(KIND_ADD,    32'hAAAA_AAAA, 16'h5555));
    send(mk(KIND_QUERY,  32'hAAAA_AAAA, 16'd0));

    repeat (460) send_random(65);
    repeat (460) send_random(15);
    calm = 1'b1;
    repeat (460) send_random(45);
    calm = 1'b0;
    repeat (470) send_random(70);
    req_valid <= 1'b0;

    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d adds, %0d removes and %0d queries; %0d results checked, %0d bad",
             tracker.n_kind[KIND_ADD], tracker.n_kind[KIND_REMOVE],
             tracker.n_kind[KIND_QUERY] + tracker.n_kind[KIND_SPARE],
             tracker.n_checked, tracker.errors);
    $display("Peak fill %0d of %0d entries, %0d adds refused when full, emptied %0d times",
             tracker.peak_fill, ENTRIES, tracker.n_drops, tracker.n_emptied);
    if (tracker.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/mct_pkg.sv
hw/rtl/mct_cell.sv
hw/rtl/mct_ctrl.sv
hw/rtl/multiset_count_table.sv
tb/multiset_count_table_tb.sv
